FILE: rtl/core/bpsc_pkg.sv
// Shared types and constants for the bitmap pattern support counter.
// No dependencies; bpsc_ctrl, bpsc_dp and the top level refer to it by scoped names.
package bpsc_pkg;

  localparam int unsigned ANALYTE_W = 8;
  localparam int unsigned INDIV_W   = 6;
  localparam int unsigned LEVEL_W   = 2;
  localparam int unsigned BIN_W     = 9;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned FREQ_W    = 17;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // item kinds
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_PATTERN = 1'b1;

  // pre-classified sample levels
  localparam logic [LEVEL_W-1:0] LVL_NORMAL  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_HIGH    = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_LOW     = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_MISSING = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CASE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CONTROLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CASES_FIRST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSING_BOTH = 2'd3;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [FREQ_W-1:0] freq_t;

  typedef struct packed {
    logic                 kind;
    logic [ANALYTE_W-1:0] analyte;
    logic [INDIV_W-1:0]   individual;
    logic [LEVEL_W-1:0]   level;
    logic [BIN_W-1:0]     pattern_bin;
    logic                 last;
  } req_t;

  typedef struct packed {
    cnt_t  group1_count;
    cnt_t  group2_count;
    freq_t group1_freq;
    freq_t group2_freq;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic exec;
    logic count_step;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic pattern_last;
    logic count_last;
    logic div_last;
  } stat_t;

endpackage

FILE: rtl/core/bpsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpsc_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/bpsc_ctrl.sv
// Sequencer for the support counter: clear pass, item execution, count scan,
// division and result hand-off. Depends on bpsc_pkg.
module bpsc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output bpsc_pkg::cmd_t  cmd,
  input  bpsc_pkg::stat_t stat
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.pattern_last ? S_COUNT : S_IDLE;
      end
      S_COUNT: begin
        cmd.count_step = 1'b1;
        if (stat.count_last) state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_load_needs_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten");

  a_clear_before_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && ($past(state) == S_CLEAR) |-> $past(stat.clear_done))
    else $error("left clear pass early");

  a_rsp_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.load_out))
    else $error("result shown without load");

endmodule

FILE: rtl/core/bpsc_dp.sv
// Datapath: config registers, bin-row RAM, pattern mask, count scan and two
// lane restoring divider. Depends on bpsc_pkg and bpsc_ram.
module bpsc_dp #(
  parameter int unsigned MAX_INDIVIDUALS    = 64,
  parameter int unsigned MAX_ANALYTES       = 256,
  parameter int unsigned FREQ_FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bpsc_pkg::cmd_t                      cmd,
  output bpsc_pkg::stat_t                     stat,
  input  bpsc_pkg::req_t                      req,
  output bpsc_pkg::rsp_t                      rsp,
  input  logic                                cfg_we,
  input  logic [bpsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpsc_pkg::CFG_W-1:0]          cfg_data
);

  localparam int unsigned MI = MAX_INDIVIDUALS;
  localparam int unsigned RW = 2 * MI;
  localparam int unsigned AW = (MAX_ANALYTES > 1) ? $clog2(MAX_ANALYTES) : 1;
  localparam int unsigned IW = (MI > 1) ? $clog2(MI) : 1;
  localparam int unsigned QW = FREQ_FRACTION_BITS + 1;
  localparam int unsigned SW = $clog2(QW);
  localparam int unsigned CW = bpsc_pkg::CNT_W;

  // configuration
  logic [CW-1:0] case_count;
  logic [CW-1:0] num_controls;
  logic          cases_first;
  logic          missing_sets_both;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_count        <= '0;
      num_controls      <= '0;
      cases_first       <= 1'b1;
      missing_sets_both <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpsc_pkg::CFG_CASE_COUNT:   case_count        <= cfg_data;
        bpsc_pkg::CFG_NUM_CONTROLS: num_controls      <= cfg_data;
        bpsc_pkg::CFG_CASES_FIRST:  cases_first       <= cfg_data[0];
        bpsc_pkg::CFG_MISSING_BOTH: missing_sets_both <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // group sizes, both saturated at the column count
  logic [CW:0]   sum_all;
  logic [CW-1:0] cases_eff;
  logic [CW-1:0] total;
  logic [CW-1:0] size [2];

  assign sum_all   = {1'b0, case_count} + {1'b0, num_controls};
  assign cases_eff = (case_count > CW'(MI)) ? CW'(MI) : case_count;
  assign total     = (sum_all > (CW + 1)'(MI)) ? CW'(MI) : sum_all[CW-1:0];
  assign size[0]   = cases_eff;
  assign size[1]   = total - cases_eff;

  // captured item
  bpsc_pkg::req_t item;

  always_ff @(posedge clk) begin
    if (cmd.accept) item <= req;
  end

  // bin-row RAM: one word per analyte, high bin in the low half
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;
  logic [AW-1:0] clr_addr;

  assign ram_raddr = (req.kind == bpsc_pkg::KIND_PATTERN)
                   ? AW'(req.pattern_bin[bpsc_pkg::BIN_W-1:1])
                   : AW'(req.analyte);

  bpsc_ram #(.WIDTH(RW), .DEPTH(MAX_ANALYTES)) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // sample write: read-modify-write of one analyte word
  logic [MI-1:0] onehot;
  logic          set_hi;
  logic          set_lo;
  logic          an_ok;
  logic          ind_ok;
  logic          sample_we;

  always_comb begin
    for (int j = 0; j < MI; j++) begin
      onehot[j] = (32'(item.individual) == j);
    end
  end

  assign an_ok  = 32'(item.analyte) < MAX_ANALYTES;
  assign ind_ok = CW'(item.individual) < total;
  assign set_hi = (item.level == bpsc_pkg::LVL_HIGH) ||
                  ((item.level == bpsc_pkg::LVL_MISSING) && missing_sets_both);
  assign set_lo = (item.level == bpsc_pkg::LVL_LOW) ||
                  ((item.level == bpsc_pkg::LVL_MISSING) && missing_sets_both);
  assign sample_we = cmd.exec && (item.kind == bpsc_pkg::KIND_SAMPLE) &&
                     an_ok && ind_ok && (set_hi || set_lo);

  assign ram_we    = cmd.clear_step || sample_we;
  assign ram_waddr = cmd.clear_step ? clr_addr : AW'(item.analyte);
  assign ram_wdata = cmd.clear_step ? '0
                   : (ram_rdata | {({MI{set_lo}} & onehot), ({MI{set_hi}} & onehot)});

  // pattern element
  logic          bin_ok;
  logic [MI-1:0] row;

  assign bin_ok = 32'(item.pattern_bin[bpsc_pkg::BIN_W-1:1]) < MAX_ANALYTES;
  assign row    = !bin_ok ? '0
                : (item.pattern_bin[0] ? ram_rdata[RW-1:MI] : ram_rdata[MI-1:0]);

  // mask and count scan, one column per cycle
  logic [MI-1:0] mask;
  logic [IW-1:0] idx;
  logic [CW-1:0] cnt [2];
  logic          start_pat;

  assign start_pat = cmd.exec && stat.pattern_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '1;
    end else if (cmd.exec && (item.kind == bpsc_pkg::KIND_PATTERN)) begin
      mask <= mask & row;
    end else if (cmd.count_step) begin
      mask <= stat.count_last ? '1 : (mask >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (start_pat) begin
      idx    <= '0;
      cnt[0] <= '0;
      cnt[1] <= '0;
    end else if (cmd.count_step) begin
      idx <= idx + IW'(1);
      if (mask[0]) begin
        if (CW'(idx) < cases_eff) begin
          cnt[0] <= cnt[0] + CW'(1);
        end else if (CW'(idx) < total) begin
          cnt[1] <= cnt[1] + CW'(1);
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle, lane 0 cases, lane 1 controls
  logic [SW-1:0] step;
  logic [CW-1:0] rem    [2];
  logic [CW:0]   rem_in [2];
  logic [1:0]    ge;
  logic [QW-1:0] quo    [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_in[l] = (step == '0) ? {1'b0, cnt[l]} : {rem[l], 1'b0};
      ge[l]     = rem_in[l] >= {1'b0, size[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (start_pat) begin
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + SW'(1);
      for (int l = 0; l < 2; l++) begin
        rem[l] <= CW'(ge[l] ? (rem_in[l] - {1'b0, size[l]}) : rem_in[l]);
        quo[l] <= {quo[l][QW-2:0], ge[l]};
      end
    end
  end

  // result register
  bpsc_pkg::freq_t freq [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      freq[l] = (size[l] == '0) ? '0 : bpsc_pkg::freq_t'(quo[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.group1_count <= cases_first ? cnt[0] : cnt[1];
      rsp.group2_count <= cases_first ? cnt[1] : cnt[0];
      rsp.group1_freq  <= cases_first ? freq[0] : freq[1];
      rsp.group2_freq  <= cases_first ? freq[1] : freq[0];
    end
  end

  assign stat.clear_done   = (clr_addr == AW'(MAX_ANALYTES - 1));
  assign stat.pattern_last = (item.kind == bpsc_pkg::KIND_PATTERN) && item.last;
  assign stat.count_last   = (idx == IW'(MI - 1));
  assign stat.div_last     = (step == SW'(QW - 1));

  a_mask_rearmed: assert property (@(posedge clk) disable iff (rst)
    cmd.count_step && stat.count_last |=> (mask == '1))
    else $error("pattern mask not rearmed after count");

  a_rem_below_size: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.div_step) && (size[0] != '0) |-> (rem[0] < size[0]))
    else $error("divider remainder out of range");

  a_cnt_within_size: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (cnt[0] <= size[0]) && (cnt[1] <= size[1]))
    else $error("group count above group size");

endmodule

FILE: rtl/core/bitmap_pattern_support_counter_top.sv
// Top level of the bitmap pattern support counter.
// Depends on bpsc_pkg, bpsc_ram, bpsc_ctrl and bpsc_dp.
//
// Usage:
//   req channel (req_valid/req_ready/req): one item per handshake. A sample
//   item sets the high or low bin bit of one individual, or both for a
//   missing level if enabled; a pattern item ANDs one bin row into the
//   running mask. A pattern item with last set makes one result on the
//   rsp channel (rsp_valid/rsp_ready/rsp); no other item makes a result.
//   cfg port: cfg_we writes cfg_data into register cfg_index.
//   Write it only while the block is idle.
// Sequence:
//   Sample and non-last pattern items read the analyte word from the
//   bin-row RAM, then write it back or AND it into the mask.
//   A last pattern item is then followed by a column-serial count, a
//   bit-serial divide and a load into the output register.
// Reset:
//   rst resets the control state, the mask (all ones) and the config
//   registers (cases_first to one, the rest to zero), then a clearing pass
//   zeroes the RAM, one word per cycle, with req_ready low.
// Stalls:
//   A held result sits in the output register while new items are taken; a
//   later result waits inside the block until the register frees.
module bitmap_pattern_support_counter_top #(
  parameter int unsigned MAX_INDIVIDUALS    = 64,
  parameter int unsigned MAX_ANALYTES       = 256,
  parameter int unsigned FREQ_FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  bpsc_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output bpsc_pkg::rsp_t                 rsp,
  input  logic                           cfg_we,
  input  logic [bpsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpsc_pkg::CFG_W-1:0]     cfg_data
);

  bpsc_pkg::cmd_t  cmd;   // sequencer commands
  bpsc_pkg::stat_t stat;  // datapath status

  // state machine: clear pass, accept, execute, scan, divide, hand off
  bpsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // storage, mask, counters, divider and result register
  bpsc_dp #(
    .MAX_INDIVIDUALS    (MAX_INDIVIDUALS),
    .MAX_ANALYTES       (MAX_ANALYTES),
    .FREQ_FRACTION_BITS (FREQ_FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
